// ===== hdl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int WORD_W  = 64;
  localparam int WORD_LG = 6;
  localparam int CNT_W   = 14;
  localparam int IDX_W   = 12;
  localparam int PRES_W  = 13;
  localparam int OPC_W   = 3;
  localparam int ONES_W  = WORD_LG + 1;

  localparam logic [OPC_W-1:0] OP_REQUEST   = 3'd0;
  localparam logic [OPC_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OPC_W-1:0] OP_LOCK      = 3'd2;
  localparam logic [OPC_W-1:0] OP_RESERVE   = 3'd3;
  localparam logic [OPC_W-1:0] OP_UNRESERVE = 3'd4;

  localparam logic [PRES_W-1:0] PRESENT_RST = 13'd4096;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_COUNT = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] hits;
    logic              last_word;
  } word_res_t;

  typedef struct packed {
    logic              any;
    logic [WORD_LG-1:0] first;
    logic [ONES_W-1:0]  ones;
  } scan_res_t;

endpackage

// ===== hdl/bitmap_page_frame_allocator.sv =====
// A request scans one 64-bit bitmap word per cycle; a range operation passes each
// word it touches through ST_EXEC and then ST_COUNT; unknown ops and empty ranges
// go straight to ST_DONE. A result still held on the output stalls the next.
// One transaction at a time; the next is taken once the result is registered.
// After reset the bitmap is cleared one word per cycle with in_tready low, and
// configuration writes are taken.
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Bitmap page allocator with a hint-driven word scan and range set/clear.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
  parameter int NUM_PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,  // pages_present
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // op[2:0], first_page[14:3], page_count[27:15]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata     // granted[0], page_index[12:1], free_pages[26:13],
                                    // used_pages[40:27], reserved_pages[54:41]
);
  import bpfa_pkg::*;

  localparam int HINT_W    = $clog2(NUM_PAGES + 1);
  localparam int POS_W     = ((HINT_W > 14) ? HINT_W : 14) + 1;
  localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [POS_W-1:0]  POS_END  = POS_W'(NUM_PAGES);
  localparam logic [HINT_W-1:0] HINT_END = HINT_W'(NUM_PAGES);
  localparam logic [WA_W-1:0]   LAST_WA  = WA_W'(NUM_WORDS - 1);

  logic [WORD_W-1:0] map_mem [NUM_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic [WA_W-1:0]   rd_addr;
  logic              wr_en;
  logic [WA_W-1:0]   wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t             state_r, state_nxt;
  logic [WA_W-1:0]    clr_r, clr_nxt;
  logic [PRES_W-1:0]  present_r;
  logic [HINT_W-1:0]  hint_r, hint_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   resv_r, resv_nxt;
  logic [OPC_W-1:0]   op_r, op_nxt;
  logic [POS_W-1:0]   cur_r, cur_nxt;
  logic [POS_W-1:0]   lim_r, lim_nxt;
  logic [POS_W-1:0]   base_r, base_nxt;
  logic [WORD_W-1:0]  hits_r, hits_nxt;
  logic               last_r, last_nxt;
  logic               granted_r, granted_nxt;
  logic [IDX_W-1:0]   page_r, page_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [55:0]        out_data_r, out_data_nxt;

  logic [OPC_W-1:0]   in_op;
  logic [IDX_W-1:0]   in_first;
  logic [PRES_W-1:0]  in_count;
  logic [POS_W-1:0]   in_sum;
  logic               in_acc;

  logic               set_mode;
  logic               clear_mode;
  logic               op_req;
  logic               op_used;
  logic               op_known;
  logic [POS_W-1:0]   cur_base;
  logic [POS_W-1:0]   next_base;
  logic [POS_W-1:0]   found_pos;
  logic [WORD_W-1:0]  scan_vec;
  logic [CNT_W-1:0]   delta;
  logic [CNT_W-1:0]   free_cnt;
  word_res_t          wu_res;
  scan_res_t          sc_res;

  bpfa_word_unit #(.POS_W(POS_W)) u_word (
    .cur      (cur_r),
    .lim      (lim_r),
    .data     (rd_data_r),
    .set_mode (set_mode),
    .res      (wu_res)
  );

  bpfa_scan_unit u_scan (
    .vec (scan_vec),
    .res (sc_res)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= map_mem[rd_addr];
  end

  assign in_op    = in_tdata[2:0];
  assign in_first = in_tdata[14:3];
  assign in_count = in_tdata[27:15];
  assign in_sum   = POS_W'(in_first) + POS_W'(in_count);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign op_req     = (op_r == OP_REQUEST);
  assign set_mode   = (op_r == OP_REQUEST) || (op_r == OP_LOCK) || (op_r == OP_RESERVE);
  assign clear_mode = (op_r == OP_FREE) || (op_r == OP_UNRESERVE);
  assign op_used    = (op_r == OP_FREE) || (op_r == OP_LOCK);
  assign op_known   = (in_op == OP_REQUEST) || (in_op == OP_FREE) || (in_op == OP_LOCK)
                   || (in_op == OP_RESERVE) || (in_op == OP_UNRESERVE);

  assign cur_base  = {cur_r[POS_W-1:WORD_LG], {WORD_LG{1'b0}}};
  assign next_base = cur_base + POS_W'(WORD_W);
  assign scan_vec  = (state_r == ST_EXEC) ? wu_res.hits : hits_r;
  assign found_pos = ((state_r == ST_EXEC) ? cur_base : base_r) + POS_W'(sc_res.first);
  assign delta     = CNT_W'(sc_res.ones);
  assign free_cnt  = CNT_W'(present_r) - used_r - resv_r;
  assign rd_addr   = cur_nxt[WORD_LG +: WA_W];

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    hint_nxt      = hint_r;
    used_nxt      = used_r;
    resv_nxt      = resv_r;
    op_nxt        = op_r;
    cur_nxt       = cur_r;
    lim_nxt       = lim_r;
    base_nxt      = base_r;
    hits_nxt      = hits_r;
    last_nxt      = last_r;
    granted_nxt   = granted_r;
    page_nxt      = page_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r[WORD_LG +: WA_W];
    wr_data       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_WA) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_op;
          granted_nxt = 1'b0;
          page_nxt    = '0;
          if (in_op == OP_REQUEST) begin
            cur_nxt = POS_W'(hint_r);
            lim_nxt = POS_END;
          end else begin
            cur_nxt = POS_W'(in_first);
            lim_nxt = (in_sum < POS_END) ? in_sum : POS_END;
          end
          state_nxt = (op_known && (cur_nxt < lim_nxt)) ? ST_EXEC : ST_DONE;
        end
      end
      ST_EXEC: begin
        wr_en = 1'b1;
        if (op_req) begin
          if (sc_res.any) begin
            wr_data     = rd_data_r | ({{(WORD_W-1){1'b0}}, 1'b1} << sc_res.first);
            hint_nxt    = HINT_W'(found_pos);
            used_nxt    = used_r + 1'b1;
            granted_nxt = 1'b1;
            page_nxt    = found_pos[IDX_W-1:0];
            state_nxt   = ST_DONE;
          end else begin
            wr_data = rd_data_r;
            if (wu_res.last_word) begin
              hint_nxt  = HINT_END;
              state_nxt = ST_DONE;
            end else begin
              cur_nxt = next_base;
            end
          end
        end else begin
          wr_data   = set_mode ? (rd_data_r | wu_res.hits) : (rd_data_r & ~wu_res.hits);
          hits_nxt  = wu_res.hits;
          base_nxt  = cur_base;
          last_nxt  = wu_res.last_word;
          cur_nxt   = next_base;
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (op_used) begin
          used_nxt = set_mode ? (used_r + delta) : (used_r - delta);
        end else begin
          resv_nxt = set_mode ? (resv_r + delta) : (resv_r - delta);
        end
        if (clear_mode && sc_res.any && (found_pos < POS_W'(hint_r))) begin
          hint_nxt = HINT_W'(found_pos);
        end
        state_nxt = last_r ? ST_DONE : ST_EXEC;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, resv_r, used_r, free_cnt, page_r, granted_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      present_r   <= PRESENT_RST;
      hint_r      <= '0;
      used_r      <= '0;
      resv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      used_r      <= used_nxt;
      resv_r      <= resv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        present_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cur_r      <= cur_nxt;
    lim_r      <= lim_nxt;
    base_r     <= base_nxt;
    hits_r     <= hits_nxt;
    last_r     <= last_nxt;
    granted_r  <= granted_nxt;
    page_r     <= page_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/bpfa_word_unit.sv =====
// ----------------------------------------------------------------------------
// bpfa_word_unit
// Masks one bitmap word to the active page window and selects the bits
// that a set or clear would change.
// ----------------------------------------------------------------------------
module bpfa_word_unit #(
  parameter int POS_W = 15
) (
  input  logic [POS_W-1:0]           cur,
  input  logic [POS_W-1:0]           lim,
  input  logic [bpfa_pkg::WORD_W-1:0] data,
  input  logic                       set_mode,
  output bpfa_pkg::word_res_t        res
);
  import bpfa_pkg::*;

  logic [POS_W-1:0]  base;
  logic [POS_W-1:0]  diff;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] mask;
  logic              span_full;

  always_comb begin
    base      = {cur[POS_W-1:WORD_LG], {WORD_LG{1'b0}}};
    diff      = lim - base;
    span_full = (diff >= POS_W'(WORD_W));
    lo_mask   = {WORD_W{1'b1}} << cur[WORD_LG-1:0];
    hi_mask   = span_full ? {WORD_W{1'b1}} : ~({WORD_W{1'b1}} << diff[WORD_LG-1:0]);
    mask      = lo_mask & hi_mask;
    res.hits  = set_mode ? (mask & ~data) : (mask & data);
    res.last_word = (diff <= POS_W'(WORD_W));
  end

endmodule

// ===== hdl/bpfa_scan_unit.sv =====
// ----------------------------------------------------------------------------
// bpfa_scan_unit
// Finds the lowest set bit of a word and counts its set bits.
// ----------------------------------------------------------------------------
module bpfa_scan_unit (
  input  logic [bpfa_pkg::WORD_W-1:0] vec,
  output bpfa_pkg::scan_res_t         res
);
  import bpfa_pkg::*;

  localparam int NIB = WORD_W / 4;
  localparam int BYT = WORD_W / 8;
  localparam int GRP = NIB / 4;

  logic [2:0]        nib_cnt [NIB];
  logic [4:0]        grp_cnt [GRP];
  logic [ONES_W-1:0] total;
  logic [BYT-1:0]    byte_any;
  logic [2:0]        byte_low [BYT];
  logic [2:0]        sel_byte;
  logic [7:0]        cur_byte;

  always_comb begin
    for (int n = 0; n < NIB; n++) begin
      nib_cnt[n] = 3'(vec[4*n]) + 3'(vec[4*n+1]) + 3'(vec[4*n+2]) + 3'(vec[4*n+3]);
    end
    for (int g = 0; g < GRP; g++) begin
      grp_cnt[g] = 5'(nib_cnt[4*g]) + 5'(nib_cnt[4*g+1])
                 + 5'(nib_cnt[4*g+2]) + 5'(nib_cnt[4*g+3]);
    end
    total = '0;
    for (int g = 0; g < GRP; g++) begin
      total = total + ONES_W'(grp_cnt[g]);
    end

    for (int b = 0; b < BYT; b++) begin
      cur_byte    = vec[8*b +: 8];
      byte_any[b] = |cur_byte;
      byte_low[b] = 3'd0;
      for (int k = 7; k >= 0; k--) begin
        if (cur_byte[k]) begin
          byte_low[b] = 3'(k);
        end
      end
    end
    sel_byte = 3'd0;
    for (int b = BYT - 1; b >= 0; b--) begin
      if (byte_any[b]) begin
        sel_byte = 3'(b);
      end
    end

    res.any   = |byte_any;
    res.first = {sel_byte, byte_low[sel_byte]};
    res.ones  = total;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocation requests and page range operations into the bitmap page
// frame allocator and checks every status transaction against a bit-level
// model of the page map, hint and page counts.
// ----------------------------------------------------------------------------
module testbench;
  import bpfa_pkg::*;

  localparam int NUM_PAGES  = 4096;
  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN_WAIT = 160;

  localparam logic [OPC_W-1:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [OPC_W-1:0] OP_UNDEF_LAST  = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0] reserved_pages;
    logic [CNT_W-1:0] used_pages;
    logic [CNT_W-1:0] free_pages;
    logic [IDX_W-1:0] page_index;
    logic             granted;
  } page_status_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [12:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  bit [NUM_PAGES-1:0] page_busy;
  logic [12:0]        scan_hint;
  logic [CNT_W-1:0]   used_pages;
  logic [CNT_W-1:0]   reserved_pages;
  logic [PRES_W-1:0]  present_pages;

  page_status_t expected_status_q[$];
  int           mismatch_count;
  int           burst_left;
  int           idle_cycles;
  rx_mode_t     rx_mode;
  int           rx_left;

  bitmap_page_frame_allocator #(.NUM_PAGES(NUM_PAGES)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #5 clk = ~clk;

  // Page map model: range set/clear with per-bit accounting.
  task automatic mark_pages(input logic [IDX_W-1:0] first, input logic [12:0] count,
                            input bit set_bit, input bit to_used);
    int idx;
    for (int t = 0; t < count; t++) begin
      idx = first + t;
      if (idx >= NUM_PAGES) break;
      if (page_busy[idx] == set_bit) continue;
      page_busy[idx] = set_bit;
      if (to_used) begin
        used_pages = set_bit ? used_pages + 14'd1 : used_pages - 14'd1;
      end else begin
        reserved_pages = set_bit ? reserved_pages + 14'd1 : reserved_pages - 14'd1;
      end
      if (!set_bit && scan_hint > idx) begin
        scan_hint = idx[12:0];
      end
    end
  endtask

  task automatic predict_page_op(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] first,
                                 input logic [12:0] count);
    page_status_t st;
    st = '0;
    case (op)
      OP_REQUEST: begin
        while (scan_hint < NUM_PAGES) begin
          if (!page_busy[scan_hint]) begin
            page_busy[scan_hint] = 1'b1;
            used_pages = used_pages + 14'd1;
            st.granted = 1'b1;
            st.page_index = scan_hint[IDX_W-1:0];
            break;
          end
          scan_hint = scan_hint + 13'd1;
        end
      end
      OP_FREE:      mark_pages(first, count, 1'b0, 1'b1);
      OP_LOCK:      mark_pages(first, count, 1'b1, 1'b1);
      OP_RESERVE:   mark_pages(first, count, 1'b1, 1'b0);
      OP_UNRESERVE: mark_pages(first, count, 1'b0, 1'b0);
      default: ;
    endcase
    st.used_pages = used_pages;
    st.reserved_pages = reserved_pages;
    st.free_pages = {1'b0, present_pages} - used_pages - reserved_pages;
    expected_status_q.push_back(st);
  endtask

  task automatic send_page_op(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] first,
                              input logic [12:0] count);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, count, first, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_page_op(op, first, count);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_pages_present(input logic [PRES_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    present_pages = value;
  endtask

  task automatic test_request_basics();
    send_page_op(OP_REQUEST, 12'd0, 13'd0);
    send_page_op(OP_REQUEST, 12'hFFF, 13'd4096);
    send_page_op(OP_REQUEST, 12'd5, 13'd3);
    for (int op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++) begin
      send_page_op(op[OPC_W-1:0], 12'd0, 13'd8);
    end
    send_page_op(OP_LOCK, 12'd10, 13'd0);
    send_page_op(OP_FREE, 12'd0, 13'd0);
  endtask

  task automatic test_range_edges();
    send_page_op(OP_LOCK, 12'hFFF, 13'd4096);
    send_page_op(OP_LOCK, 12'd64, 13'd4095);
    send_page_op(OP_RESERVE, 12'd0, 13'd4096);
    send_page_op(OP_REQUEST, 12'd0, 13'd0);
    send_page_op(OP_FREE, 12'd100, 13'd1);
    send_page_op(OP_REQUEST, 12'd0, 13'd0);
    send_page_op(OP_UNRESERVE, 12'd0, 13'd4096);
    send_page_op(OP_FREE, 12'd0, 13'd4096);
    send_page_op(OP_REQUEST, 12'd0, 13'd0);
  endtask

  task automatic test_present_extremes();
    set_pages_present(13'd0);
    send_page_op(OP_UNDEF_LAST, 12'd0, 13'd0);
    send_page_op(OP_REQUEST, 12'd0, 13'd0);
    set_pages_present(13'd4095);
    send_page_op(OP_RESERVE, 12'd2, 13'd3);
    set_pages_present(PRESENT_RST);
    send_page_op(OP_REQUEST, 12'd0, 13'd0);
  endtask

  task automatic send_random_page_op();
    int sel;
    logic [OPC_W-1:0] op;
    logic [IDX_W-1:0] first;
    logic [12:0]      count;
    sel = $urandom_range(0, 99);
    if (sel < 40) op = OP_REQUEST;
    else if (sel < 58) op = OP_FREE;
    else if (sel < 70) op = OP_LOCK;
    else if (sel < 82) op = OP_RESERVE;
    else if (sel < 95) op = OP_UNRESERVE;
    else op = OPC_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
    sel = $urandom_range(0, 99);
    if (sel < 70) first = IDX_W'($urandom_range(0, 255));
    else if (sel < 95) first = IDX_W'($urandom_range(0, NUM_PAGES - 1));
    else first = IDX_W'($urandom_range(NUM_PAGES - 64, NUM_PAGES - 1));
    sel = $urandom_range(0, 99);
    if (sel < 80) count = 13'($urandom_range(0, 32));
    else if (sel < 95) count = 13'($urandom_range(33, 300));
    else if (sel < 98) count = 13'($urandom_range(301, NUM_PAGES));
    else count = 13'(NUM_PAGES);
    send_page_op(op, first, count);
  endtask

  task automatic test_random_traffic();
    int sel;
    for (int phase = 0; phase < 4; phase++) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) set_pages_present(13'd0);
      else if (sel == 1) set_pages_present(PRESENT_RST);
      else set_pages_present(PRES_W'($urandom_range(0, NUM_PAGES)));
      repeat (150) send_random_page_op();
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_tready <= ($urandom_range(0, 3) == 0);
      default:  out_tready <= (rx_left % 7) < 4;
    endcase
  end

  always @(posedge clk) begin
    page_status_t got;
    page_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = page_status_t'(out_tdata[54:0]);
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transaction: %p", got);
        end
      end else begin
        want = expected_status_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t: expected granted=%0d page=%0d free=%0d used=%0d rsv=%0d",
                     $realtime, want.granted, want.page_index, $signed(want.free_pages),
                     $signed(want.used_pages), $signed(want.reserved_pages));
            $display("                  actual granted=%0d page=%0d free=%0d used=%0d rsv=%0d",
                     got.granted, got.page_index, $signed(got.free_pages),
                     $signed(got.used_pages), $signed(got.reserved_pages));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    page_busy      = '0;
    scan_hint      = '0;
    used_pages     = '0;
    reserved_pages = '0;
    present_pages  = PRESENT_RST;
    mismatch_count = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    rx_left        = 0;
    rx_mode        = RX_OPEN;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_request_basics();
    test_range_edges();
    test_present_extremes();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bpfa_pkg.sv
hdl/bpfa_word_unit.sv
hdl/bpfa_scan_unit.sv
hdl/bitmap_page_frame_allocator.sv
dv/testbench.sv
